[src/poly_a_t_read_trimmer_assert.svh]
// Assertion macros shared by the poly-A/T read trimmer RTL.
`ifndef POLY_A_T_READ_TRIMMER_ASSERT_SVH
`define POLY_A_T_READ_TRIMMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poly_a_t_read_trimmer: assertion failed");

// Next-cycle implication, checked out of reset.
`define PAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poly_a_t_read_trimmer: assertion failed");

`endif

[src/pat_pkg.sv]
// Package: item types, register map and constants of the poly-A/T read trimmer.
package pat_pkg;

    typedef struct packed {
        logic [7:0] base_char;
        logic       last_of_read;
    } pat_in_t;

    typedef struct packed {
        logic signed [10:0] begin_pos;
        logic signed [11:0] end_pos;
        logic               keep_read;
        logic        [10:0] read_length;
        logic        [31:0] total_trimmed;
        logic               too_long;
    } pat_out_t;

    // Per-letter tracker status for the current base
    typedef struct packed {
        logic hit;
        logic found;
        logic over;
    } pat_trk_t;

    localparam int CFG_AW = 4;
    localparam int ADD_W  = 34;

    typedef enum logic [1:0] {
        REG_MIN_TAIL = 2'd0,
        REG_MAX_MISM = 2'd1,
        REG_MIN_KEPT = 2'd2
    } pat_reg_e;

    localparam logic [10:0] MIN_TAIL_RST = 11'd20;
    localparam logic [3:0]  MAX_MISM_RST = 4'd3;
    localparam logic [10:0] MIN_KEPT_RST = 11'd40;

    localparam logic [7:0] LETTER_A = 8'h41;
    localparam logic [7:0] LETTER_T = 8'h54;

endpackage

[src/pat_cell.sv]
// Mismatch history cell: one position entry of a letter's shift chain.
module pat_cell #(
    parameter int PW  = 10,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          shift,
    input  logic [PW-1:0] d,
    input  logic [CW-1:0] sel,
    output logic [PW-1:0] q,
    output logic [PW-1:0] tap
);

    logic [PW-1:0] hist_reg;
    logic [PW-1:0] hist_next;

    assign hist_next = shift ? d : hist_reg;

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign q   = hist_reg;
    assign tap = (sel == CW'(IDX)) ? hist_next : '0;

endmodule

[src/pat_track.sv]
// Per-letter tracker: mismatch count and head stop position.
module pat_track import pat_pkg::*; #(
    parameter int          PW     = 10,
    parameter int          CW     = 5,
    parameter int          DEPTH  = 16,
    parameter logic [7:0]  LETTER = LETTER_A
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          acc,
    input  logic          upd_en,
    input  logic          clear,
    input  logic [7:0]    base,
    input  logic [PW-1:0] pos,
    input  logic [CW-1:0] m,
    output pat_trk_t      stat,
    output logic [PW-1:0] stop_upd
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_upd;
    logic          found_reg;
    logic          found_next;
    logic [PW-1:0] stop_reg;
    logic          hit;
    logic          over;
    logic          first_over;

    assign hit        = upd_en && (base != LETTER);
    assign count_upd  = (hit && (count_reg < CW'(DEPTH))) ? count_reg + CW'(1) : count_reg;
    assign over       = count_upd > m;
    assign first_over = hit && !found_reg && over;
    assign stop_upd   = first_over ? pos : stop_reg;

    always_comb
    begin
        count_next = count_reg;
        found_next = found_reg;
        if (acc)
        begin
            count_next = clear ? '0 : count_upd;
            found_next = clear ? 1'b0 : (found_reg || first_over);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            stop_reg <= stop_upd;
        end
    end

    assign stat.hit   = hit;
    assign stat.found = found_reg || first_over;
    assign stat.over  = over;

endmodule

[src/poly_a_t_read_trimmer.sv]
// Top level of the poly-A/T read trimmer: config port, trackers, history chains, cut pipeline.
//
// Takes one base per clock cycle while base_ready is high, with no gaps
// between reads. Mismatch positions for 'A' and 'T' shift down two chains
// of MAX_ERRORS+1 cells, one step per mismatching base, so the tail cut
// needs no backward walk. Results pass through the snapshot, cut, keep/add
// and total register stages and may follow every cycle while result_ready
// is high; the output register lets the next read stream in while a result
// waits. Bases past MAX_READ_LEN are only counted.
`include "poly_a_t_read_trimmer_assert.svh"

module poly_a_t_read_trimmer import pat_pkg::*; #(
    parameter int MAX_READ_LEN = 1024,
    parameter int MAX_ERRORS   = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              base_valid,
    output logic              base_ready,
    input  pat_in_t           base_item,
    output logic              result_valid,
    input  logic              result_ready,
    output pat_out_t          result_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PW = $clog2(MAX_READ_LEN);
    localparam int LW = $clog2(MAX_READ_LEN + 1);
    localparam int HD = MAX_ERRORS + 1;
    localparam int CW = $clog2(MAX_ERRORS + 2);
    localparam int XW = ((LW > 12) ? LW : 12) + 2;
    localparam logic signed [XW-1:0] ONE_X = 1;

    // Configuration registers
    logic [10:0] min_tail_reg;
    logic [3:0]  max_mism_reg;
    logic [10:0] min_kept_reg;
    pat_reg_e    cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = pat_reg_e'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tail_reg <= MIN_TAIL_RST;
            max_mism_reg <= MAX_MISM_RST;
            min_kept_reg <= MIN_KEPT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MIN_TAIL: min_tail_reg <= pwdata[10:0];
                REG_MAX_MISM: max_mism_reg <= pwdata[3:0];
                REG_MIN_KEPT: min_kept_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_TAIL: prdata = 32'(min_tail_reg);
            REG_MAX_MISM: prdata = 32'(max_mism_reg);
            REG_MIN_KEPT: prdata = 32'(min_kept_reg);
            default:      prdata = '0;
        endcase
    end

    logic [CW-1:0] m_eff;

    assign m_eff = (int'(max_mism_reg) > MAX_ERRORS) ? CW'(MAX_ERRORS) : CW'(max_mism_reg);

    // Read position and base tally
    logic          acc;
    logic          last;
    logic          upd_en;
    logic [LW-1:0] pos_reg;
    logic [LW-1:0] pos_upd;
    logic [31:0]   bases_reg;
    logic [31:0]   bases_upd;
    logic          ovf_reg;
    logic          ovf_upd;
    logic [PW-1:0] pos_p;

    assign acc       = base_valid && base_ready;
    assign last      = base_item.last_of_read;
    assign upd_en    = !ovf_reg && (pos_reg < LW'(MAX_READ_LEN));
    assign pos_upd   = upd_en ? pos_reg + LW'(1) : pos_reg;
    assign ovf_upd   = ovf_reg || !upd_en;
    assign bases_upd = (bases_reg == 32'hFFFF_FFFF) ? bases_reg : bases_reg + 32'd1;
    assign pos_p     = PW'(pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            bases_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (acc)
        begin
            pos_reg   <= last ? '0 : pos_upd;
            bases_reg <= last ? '0 : bases_upd;
            ovf_reg   <= last ? 1'b0 : ovf_upd;
        end
    end

    // Letter trackers
    pat_trk_t      stat_a;
    pat_trk_t      stat_t;
    logic [PW-1:0] stop_a;
    logic [PW-1:0] stop_t;

    pat_track #(.PW(PW), .CW(CW), .DEPTH(HD), .LETTER(LETTER_A)) u_track_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .upd_en   (upd_en),
        .clear    (last),
        .base     (base_item.base_char),
        .pos      (pos_p),
        .m        (m_eff),
        .stat     (stat_a),
        .stop_upd (stop_a)
    );

    pat_track #(.PW(PW), .CW(CW), .DEPTH(HD), .LETTER(LETTER_T)) u_track_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .upd_en   (upd_en),
        .clear    (last),
        .base     (base_item.base_char),
        .pos      (pos_p),
        .m        (m_eff),
        .stat     (stat_t),
        .stop_upd (stop_t)
    );

    // History chains
    logic [PW-1:0] hist_a [HD];
    logic [PW-1:0] hist_t [HD];
    logic [PW-1:0] tap_a  [HD];
    logic [PW-1:0] tap_t  [HD];

    for (genvar i = 0; i < HD; i++)
    begin : g_chain
        logic [PW-1:0] din_a;
        logic [PW-1:0] din_t;

        if (i == 0)
        begin : g_head
            assign din_a = pos_p;
            assign din_t = pos_p;
        end
        else
        begin : g_link
            assign din_a = hist_a[i-1];
            assign din_t = hist_t[i-1];
        end

        pat_cell #(.PW(PW), .CW(CW), .IDX(i)) u_cell_a (
            .clk   (clk),
            .shift (acc && stat_a.hit),
            .d     (din_a),
            .sel   (m_eff),
            .q     (hist_a[i]),
            .tap   (tap_a[i])
        );

        pat_cell #(.PW(PW), .CW(CW), .IDX(i)) u_cell_t (
            .clk   (clk),
            .shift (acc && stat_t.hit),
            .d     (din_t),
            .sel   (m_eff),
            .q     (hist_t[i]),
            .tap   (tap_t[i])
        );
    end

    logic [PW-1:0] sel_a;
    logic [PW-1:0] sel_t;

    always_comb
    begin
        sel_a = '0;
        sel_t = '0;
        for (int i = 0; i < HD; i++)
        begin
            sel_a = sel_a | tap_a[i];
            sel_t = sel_t | tap_t[i];
        end
    end

    // Pipeline handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_take;
    logic s2_take;
    logic s3_take;
    logic out_take;
    logic out_load;

    assign out_take   = !result_valid || result_ready;
    assign s3_take    = !s3_valid_reg || out_take;
    assign s2_take    = !s2_valid_reg || s3_take;
    assign s1_take    = !s1_valid_reg || s2_take;
    assign base_ready = s1_take;
    assign out_load   = s3_valid_reg && out_take;

    // Stage 1: end-of-read snapshot
    logic          s1_ovf;
    logic [LW-1:0] s1_len;
    logic [31:0]   s1_bases;
    logic          s1_a_found;
    logic          s1_t_found;
    logic          s1_a_over;
    logic          s1_t_over;
    logic [PW-1:0] s1_a_stop;
    logic [PW-1:0] s1_t_stop;
    logic [PW-1:0] s1_a_tap;
    logic [PW-1:0] s1_t_tap;

    always_ff @(posedge clk)
    begin
        if (s1_take && acc && last)
        begin
            s1_ovf     <= ovf_upd;
            s1_len     <= pos_upd;
            s1_bases   <= bases_upd;
            s1_a_found <= stat_a.found;
            s1_t_found <= stat_t.found;
            s1_a_over  <= stat_a.over;
            s1_t_over  <= stat_t.over;
            s1_a_stop  <= stop_a;
            s1_t_stop  <= stop_t;
            s1_a_tap   <= sel_a;
            s1_t_tap   <= sel_t;
        end
    end

    // Stage 2: head and tail cuts
    logic signed [XW-1:0] len_x;
    logic signed [XW-1:0] tail_x;
    logic signed [XW-1:0] pa;
    logic signed [XW-1:0] pt;
    logic signed [XW-1:0] head_a;
    logic signed [XW-1:0] head_t;
    logic signed [XW-1:0] qa;
    logic signed [XW-1:0] qt;
    logic signed [XW-1:0] rem_a;
    logic signed [XW-1:0] rem_t;
    logic signed [XW-1:0] cut_a;
    logic signed [XW-1:0] cut_t;
    logic signed [XW-1:0] begin_x;
    logic signed [XW-1:0] end_x;

    assign len_x  = signed'(XW'(s1_len));
    assign tail_x = signed'(XW'(min_tail_reg));
    assign pa     = s1_a_found ? signed'(XW'(s1_a_stop)) : len_x;
    assign pt     = s1_t_found ? signed'(XW'(s1_t_stop)) : len_x;
    assign head_a = (pa < tail_x) ? '0 : pa - ONE_X;
    assign head_t = (pt < tail_x) ? '0 : pt - ONE_X;
    assign qa     = s1_a_over ? signed'(XW'(s1_a_tap)) : -ONE_X;
    assign qt     = s1_t_over ? signed'(XW'(s1_t_tap)) : -ONE_X;
    assign rem_a  = len_x - qa - ONE_X;
    assign rem_t  = len_x - qt - ONE_X;
    assign cut_a  = (rem_a < tail_x) ? len_x : qa;
    assign cut_t  = (rem_t < tail_x) ? len_x : qt;

    always_comb
    begin
        if (s1_ovf)
        begin
            begin_x = '0;
            end_x   = '0;
        end
        else
        begin
            begin_x = (head_a == '0) ? head_t : head_a;
            end_x   = (cut_a == len_x) ? cut_t : cut_a;
        end
    end

    logic                 s2_ovf;
    logic [LW-1:0]        s2_len;
    logic [31:0]          s2_bases;
    logic signed [XW-1:0] s2_begin;
    logic signed [XW-1:0] s2_end;

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_valid_reg)
        begin
            s2_ovf   <= s1_ovf;
            s2_len   <= s1_len;
            s2_bases <= s1_bases;
            s2_begin <= begin_x;
            s2_end   <= end_x;
        end
    end

    // Stage 3: keep decision and trimmed count
    logic signed [XW-1:0]    diff_x;
    logic signed [XW-1:0]    len2_x;
    logic signed [XW-1:0]    kept_x;
    logic                    keep;
    logic signed [ADD_W-1:0] add_x;

    assign diff_x = s2_end - s2_begin;
    assign len2_x = signed'(XW'(s2_len));
    assign kept_x = signed'(XW'(min_kept_reg));
    assign keep   = !s2_ovf && (diff_x >= kept_x);

    always_comb
    begin
        if (s2_ovf)
        begin
            add_x = signed'(ADD_W'(s2_bases));
        end
        else if (keep)
        begin
            add_x = ADD_W'(len2_x - diff_x);
        end
        else
        begin
            add_x = ADD_W'(len2_x);
        end
    end

    logic                    s3_ovf;
    logic                    s3_keep;
    logic [LW-1:0]           s3_len;
    logic signed [XW-1:0]    s3_begin;
    logic signed [XW-1:0]    s3_end;
    logic signed [ADD_W-1:0] s3_add;

    always_ff @(posedge clk)
    begin
        if (s3_take && s2_valid_reg)
        begin
            s3_ovf   <= s2_ovf;
            s3_keep  <= keep;
            s3_len   <= s2_len;
            s3_begin <= s2_begin;
            s3_end   <= s2_end;
            s3_add   <= add_x;
        end
    end

    // Output stage: saturating running total
    logic [31:0]             trimmed_total_reg;
    logic [31:0]             total_next;
    logic signed [ADD_W-1:0] sum_x;

    assign sum_x = signed'(ADD_W'(trimmed_total_reg)) + s3_add;

    always_comb
    begin
        if (sum_x[ADD_W-1])
        begin
            total_next = '0;
        end
        else if (sum_x[32])
        begin
            total_next = '1;
        end
        else
        begin
            total_next = sum_x[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_item.begin_pos     <= 11'(s3_begin);
            result_item.end_pos       <= 12'(s3_end);
            result_item.keep_read     <= s3_keep;
            result_item.read_length   <= 11'(s3_len);
            result_item.total_trimmed <= total_next;
            result_item.too_long      <= s3_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            result_valid      <= 1'b0;
            trimmed_total_reg <= '0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= acc && last;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_take)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_take)
            begin
                result_valid <= s3_valid_reg;
            end
            if (out_load)
            begin
                trimmed_total_reg <= total_next;
            end
        end
    end

    `PAT_ASSERT_NXT(a_last_snapshot, acc && last, s1_valid_reg)
    `PAT_ASSERT_IMP(a_ovf_at_max, ovf_reg, pos_reg == LW'(MAX_READ_LEN))
    `PAT_ASSERT_NXT(a_out_drains, result_valid && result_ready && !s3_valid_reg, !result_valid)
    `PAT_ASSERT_NXT(a_out_loads, s3_valid_reg && out_take, result_valid)

endmodule
